### sv/seven_segment_bitplane_formatter_defines.svh
// Assertion macros for the seven-segment bit-plane formatter.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef SEVEN_SEGMENT_BITPLANE_FORMATTER_DEFINES_SVH
`define SEVEN_SEGMENT_BITPLANE_FORMATTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SSBF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SSBF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must never hold out of reset.
`define SSBF_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

### sv/ssbf_pkg.sv
// Shared types, constants and segment table for the bit-plane formatter.
// No dependencies.
package ssbf_pkg;

  localparam int VALUE_W      = 24;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 24'd9999999;
  localparam int DIGITS       = 7;
  localparam int BCD_W        = 4 * DIGITS;
  localparam int SHOWN        = 4;
  localparam int SEG_W        = 7;
  localparam int FRAME_BYTES  = 32;
  localparam int BYTE_IDX_W   = $clog2(FRAME_BYTES);
  localparam int QUEUE_DEPTH  = 2;
  localparam int MAXDEC_W     = 2;
  localparam logic [MAXDEC_W-1:0] MAXDEC_RESET = 2'd3;
  localparam int LEAD_BLANK_MAX = 3;

  // segment codes, bit order gfedcba
  localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;

  typedef struct packed {
    logic [SHOWN-1:0][SEG_W-1:0] code;   // code[0] is the leftmost shown digit
  } frame_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] d, input logic blank);
    logic [SEG_W-1:0] c;
    case (d)
      4'd0:    c = 7'h3F;
      4'd1:    c = 7'h06;
      4'd2:    c = 7'h5B;
      4'd3:    c = 7'h4F;
      4'd4:    c = 7'h66;
      4'd5:    c = 7'h6D;
      4'd6:    c = 7'h7D;
      4'd7:    c = 7'h07;
      4'd8:    c = 7'h7F;
      4'd9:    c = 7'h6F;
      default: c = SEG_BLANK;
    endcase
    return blank ? SEG_BLANK : c;
  endfunction

endpackage

### sv/ssbf_front.sv
// Front end: accepts a value, converts it to BCD by shift-and-add-3,
// then blanks, windows and encodes the digits into a frame. Uses ssbf_pkg.
module ssbf_front
  import ssbf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [VALUE_W-1:0]  in_value_milli,
  input  logic [MAXDEC_W-1:0] max_decimals,
  input  qstat_t              q_stat,
  output logic                push,
  output frame_t              push_frame
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  localparam int CNT_W = $clog2(VALUE_W);

  front_state_t       state_r, state_nxt;
  logic [VALUE_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic [BCD_W-1:0]   bcd_adj;
  logic [3:0]         dig   [DIGITS];
  logic [SEG_W-1:0]   codes [DIGITS];
  logic [1:0]         blanked;
  logic [1:0]         offset;
  logic [2:0]         idx;

  assign busy = (state_r != F_IDLE);

  // add-3 on every nibble that is 5 or more
  always_comb begin
    for (int j = 0; j < DIGITS; j++) begin
      bcd_adj[4*j +: 4] = (bcd_r[4*j +: 4] >= 4'd5) ? bcd_r[4*j +: 4] + 4'd3
                                                     : bcd_r[4*j +: 4];
    end
  end

  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    push      = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (start) begin
          bin_nxt   = (in_value_milli > VALUE_MAX) ? VALUE_MAX : in_value_milli;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = F_CONV;
        end
      end
      F_CONV: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[VALUE_W-1]};
        bin_nxt = {bin_r[VALUE_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(VALUE_W - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_stat.full) begin
          push      = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // classification: leading-zero blanking, window offset, segment codes
  always_comb begin
    for (int j = 0; j < DIGITS; j++) begin
      dig[j] = bcd_r[BCD_W-1-4*j -: 4];
    end
    if (dig[0] != 4'd0)      blanked = 2'd0;
    else if (dig[1] != 4'd0) blanked = 2'd1;
    else if (dig[2] != 4'd0) blanked = 2'd2;
    else                     blanked = 2'(LEAD_BLANK_MAX);
    offset = (blanked < max_decimals) ? blanked : max_decimals;
    for (int j = 0; j < DIGITS; j++) begin
      codes[j] = seg_code(dig[j], (j < LEAD_BLANK_MAX) && (2'(j) < blanked));
    end
    idx = 3'd0;
    for (int k = 0; k < SHOWN; k++) begin
      idx = {1'b0, offset} + 3'(k);
      push_frame.code[k] = codes[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

### sv/ssbf_queue.sv
// Short frame queue between front and back ends.
// Uses ssbf_pkg for the frame type and status struct.
module ssbf_queue
  import ssbf_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  frame_t push_frame,
  input  logic   pop,
  output frame_t head,
  output qstat_t q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_t           entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign head         = entry_r[rd_ptr_r];
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == CNT_W'(DEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      entry_r[wr_ptr_r] <= push_frame;
    end
  end

endmodule

### sv/ssbf_back.sv
// Back end: streams the head frame as 32 bit-plane bytes, one per cycle.
// Uses ssbf_pkg.
module ssbf_back
  import ssbf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  frame_t     head,
  input  qstat_t     q_stat,
  output logic       pop,
  output logic       out_strobe,
  output logic [7:0] out_frame_byte,
  output logic       out_last_byte
);

  logic [BYTE_IDX_W-1:0] n_r, n_nxt;
  logic                  strobe_r;
  logic [7:0]            byte_r, byte_nxt;
  logic                  last_r, last_nxt;
  logic [2:0]            plane_rot;
  logic [7:0]            mask;
  logic [SEG_W-1:0]      code;
  logic                  active;

  assign active    = !q_stat.empty;
  // plane p uses mask bit (p+1) mod 8: 0x02 .. 0x80, then 0x01
  assign plane_rot = n_r[BYTE_IDX_W-1 -: 3] + 3'd1;
  assign mask      = 8'd1 << plane_rot;
  assign code      = head.code[n_r[1:0]];
  assign byte_nxt  = ~({1'b0, code} & mask);
  assign last_nxt  = active && (n_r == BYTE_IDX_W'(FRAME_BYTES - 1));
  assign pop       = last_nxt;
  assign n_nxt     = active ? n_r + 1'b1 : n_r;

  assign out_strobe     = strobe_r;
  assign out_frame_byte = byte_r;
  assign out_last_byte  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r      <= '0;
      strobe_r <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      n_r      <= n_nxt;
      strobe_r <= active;
      last_r   <= last_nxt;
    end
    byte_r <= byte_nxt;
  end

endmodule

### sv/seven_segment_bitplane_formatter.sv
// Top level of the seven-segment bit-plane formatter.
// Depends on ssbf_pkg, ssbf_front, ssbf_queue, ssbf_back and the defines header.
//
// Each value (thousandths, saturated at 9999999) becomes one frame of 32 bytes
// on out_frame_byte, one byte per cycle with out_strobe high for that cycle,
// out_last_byte marking the 32nd. The receiver cannot stall: bytes leave on
// consecutive cycles and must be taken as they come. A value is taken at a
// clock edge with start high and busy low. The front end works through an idle
// state, 24 shift-and-add-3 BCD steps and a classify/push state for each value.
// The back end emits one byte per cycle while a frame is queued; the byte
// stream sets the sustained throughput. A two-frame queue sits between the
// halves, so the front converts the next value while the back streams the
// current one; a converted frame waits in the front, with busy high, while the
// queue is full. A frame already queued follows the previous one without a
// gap. max_decimals is written through the cfg_ channel (always ready) and
// should only change while no frame is pending.

`include "seven_segment_bitplane_formatter_defines.svh"

module seven_segment_bitplane_formatter
  import ssbf_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  // command channel
  input  logic                start,
  output logic                busy,
  input  logic [VALUE_W-1:0]  in_value_milli,
  // result stream
  output logic                out_strobe,
  output logic [7:0]          out_frame_byte,
  output logic                out_last_byte,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [MAXDEC_W-1:0] cfg_max_decimals
);

  logic [MAXDEC_W-1:0] max_decimals_r;
  logic                push;
  logic                pop;
  frame_t              push_frame;
  frame_t              head;
  qstat_t              q_stat;

  // config register; writes are accepted every cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_decimals_r <= MAXDEC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_decimals_r <= cfg_max_decimals;
    end
  end

  // front: BCD conversion and digit classification
  ssbf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value_milli (in_value_milli),
    .max_decimals   (max_decimals_r),
    .q_stat         (q_stat),
    .push           (push),
    .push_frame     (push_frame)
  );

  // frame queue decoupling the two halves
  ssbf_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // back: bit-plane byte stream
  ssbf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_stat         (q_stat),
    .pop            (pop),
    .out_strobe     (out_strobe),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

  // checks
  `SSBF_ASSERT_NOW(a_last_has_strobe, out_last_byte, out_strobe, "last byte without strobe")
  `SSBF_ASSERT_NEXT(a_last_spaced, out_last_byte, !out_last_byte, "back-to-back last bytes")
  `SSBF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not set busy")
  `SSBF_ASSERT_NEVER(a_queue_stat, q_stat.full && q_stat.empty, "queue full and empty")
  `SSBF_ASSERT_NEVER(a_push_full, push && q_stat.full && !pop, "push into full queue")

endmodule

### tb/seven_segment_bitplane_formatter_test.sv
// Self-checking testbench for the seven-segment bit-plane formatter.
// Depends on ssbf_pkg and the seven_segment_bitplane_formatter top level.
// Values go in through start/busy; every 32-byte frame is predicted and checked.

module seven_segment_bitplane_formatter_test;
  import ssbf_pkg::*;

  // Run limit in clock cycles. The slowest correct run is about 410 items,
  // each costing a frame, a front-end conversion and the longest gap, so this
  // is a wide margin.
  localparam int CYCLE_LIMIT   = 400000;
  // Cycles to let pass once the last expected byte has arrived.
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 47;

  // Seven-segment codes for digits 0..9, bit order gfedcba.
  localparam logic [7:0] DIGIT_SEGMENTS [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };
  localparam logic [7:0] BLANK_SEGMENTS = 8'h00;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } segment_byte_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [VALUE_W-1:0]  in_value_milli = '0;
  logic                out_strobe;
  logic [7:0]          out_frame_byte;
  logic                out_last_byte;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [MAXDEC_W-1:0] cfg_max_decimals = '0;

  // Mirror of the block's one configuration register.
  logic [MAXDEC_W-1:0] shown_decimals;
  // Bytes still owed by the block, oldest first.
  segment_byte_t       pending_bytes[$];
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count = 0;

  seven_segment_bitplane_formatter u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_value_milli   (in_value_milli),
    .out_strobe       (out_strobe),
    .out_frame_byte   (out_frame_byte),
    .out_last_byte    (out_last_byte),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_max_decimals (cfg_max_decimals)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung block or a lost handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Works out the 32 bytes of one frame and appends them to pending_bytes.
  task automatic predict_frame(input logic [VALUE_W-1:0] value_milli);
    int unsigned   v;
    int unsigned   digit [DIGITS];
    bit            blank [DIGITS];
    int unsigned   lead_blanks;
    int unsigned   window;
    logic [7:0]    code [SHOWN];
    logic [7:0]    plane_mask;
    segment_byte_t b;
    int            n;
    v = value_milli;
    if (v > VALUE_MAX) v = VALUE_MAX;          // saturate
    for (int k = DIGITS - 1; k >= 0; k--) begin
      digit[k] = v % 10;
      blank[k] = 1'b0;
      v = v / 10;
    end
    // At most three leading zeros blank; an all-zero value keeps "0.000".
    lead_blanks = 0;
    while (lead_blanks < LEAD_BLANK_MAX && digit[lead_blanks] == 0) begin
      blank[lead_blanks] = 1'b1;
      lead_blanks++;
    end
    window = (lead_blanks < shown_decimals) ? lead_blanks : shown_decimals;
    for (int k = 0; k < SHOWN; k++) begin
      code[k] = blank[window + k] ? BLANK_SEGMENTS : DIGIT_SEGMENTS[digit[window + k]];
    end
    // Planes 0x02 .. 0x80, then 0x01; four digits per plane.
    plane_mask = 8'h01;
    n = 0;
    for (int p = 0; p < 8; p++) begin
      plane_mask = {plane_mask[6:0], plane_mask[7]};
      for (int k = 0; k < SHOWN; k++) begin
        b.frame_byte = ~(code[k] & plane_mask);
        b.last_byte  = (n == FRAME_BYTES - 1);
        pending_bytes.push_back(b);
        n++;
      end
    end
  endtask

  // Result checker: the receiver cannot stall, so every strobe is one byte.
  always @(posedge clk) begin
    segment_byte_t want;
    if (rst_n && out_strobe) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t unexpected byte: expected none, actual byte %02h last %0b",
                 $time, out_frame_byte, out_last_byte);
        mismatch_count++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_frame_byte !== want.frame_byte) begin
          $display("%0t frame_byte: expected %02h, actual %02h",
                   $time, want.frame_byte, out_frame_byte);
          mismatch_count++;
        end
        if (out_last_byte !== want.last_byte) begin
          $display("%0t last_byte: expected %0b, actual %0b",
                   $time, want.last_byte, out_last_byte);
          mismatch_count++;
        end
      end
    end
  end

  // Mostly back-to-back or short gaps, a few long ones so that an idle start
  // lands on every byte position of the frame in flight.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // Values spread over digit counts so every blanking depth shows up often.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VALUE_W'($urandom_range(0, 9));
      1:       return VALUE_W'($urandom_range(0, 999));
      2:       return VALUE_W'($urandom_range(1000, 9999));
      3:       return VALUE_W'($urandom_range(10000, 99999));
      4:       return VALUE_W'($urandom_range(100000, 999999));
      5:       return VALUE_W'($urandom_range(1000000, 9999999));
      6:       return VALUE_W'($urandom_range(9999990, 10000010));
      default: return VALUE_W'($urandom());   // full range, saturation too
    endcase
  endfunction

  // Sends one item after an idle gap. start is left high after acceptance so
  // a gap-free next item keeps it high without a drop.
  task automatic send_value(input logic [VALUE_W-1:0] value, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_value_milli <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_frame(value);
  endtask

  // Sender holds off until the block has delivered everything owed.
  task automatic wait_frames_drained();
    start <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  // Register write, only with the block idle.
  task automatic write_max_decimals(input logic [MAXDEC_W-1:0] value);
    wait_frames_drained();
    repeat (4) @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_max_decimals <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid      <= 1'b0;
    shown_decimals  = value;
  endtask

  // Reset setting (three decimals): field extremes and saturation.
  task automatic test_reset_setting();
    send_value(24'd0, 0);
    send_value(24'd1, 0);
    send_value(24'd9999999, 0);
    send_value(24'd10000000, 1);
    send_value(24'hFFFFFF, 0);
    send_value(24'd1234567, 2);
  endtask

  // Every decimal limit against blanking depths of none, two and three digits.
  task automatic test_decimal_limits();
    for (int d = 0; d < 4; d++) begin
      write_max_decimals(d[MAXDEC_W-1:0]);
      send_value(24'd0, 0);        // all zero: only three digits blank
      send_value(24'd7, 0);
      send_value(24'd45012, 0);
      send_value(24'd8000001, 0);
    end
  endtask

  // Pause the sender until the pipe is empty, then restart back to back.
  task automatic test_restart_after_drain();
    for (int i = 0; i < 10; i++) begin
      if (i == 5) wait_frames_drained();
      send_value(pick_value(), 0);
    end
  endtask

  // Random phases, each with its own setting; the first two are the extremes.
  task automatic test_random_values();
    logic [MAXDEC_W-1:0] setting;
    bit                  no_gaps;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      setting = (ph == 0) ? 2'd0 : (ph == 1) ? 2'd3 : MAXDEC_W'($urandom_range(0, 3));
      write_max_decimals(setting);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_value(pick_value(), no_gaps ? 0 : pick_gap());
      end
    end
  endtask

  initial begin
    shown_decimals = MAXDEC_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_setting();
    test_decimal_limits();
    test_restart_after_drain();
    test_random_values();

    wait_frames_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### seven_segment_bitplane_formatter.f
+incdir+sv
sv/ssbf_pkg.sv
sv/ssbf_front.sv
sv/ssbf_queue.sv
sv/ssbf_back.sv
sv/seven_segment_bitplane_formatter.sv
tb/seven_segment_bitplane_formatter_test.sv
